/* hdl/ppe_pkg.sv */
// ppe_pkg: widths, fixed-point constants, eddy coefficient table and the
// coefficient conversion used by the pedal power estimator
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package ppe_pkg;

    // port field widths
    localparam int RPM_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int WATTS_W = 16;

    // rpm to rad/s scale, Q0.24, and the product with the rpm field
    localparam int RATE_W      = 24;
    localparam int RATE_PROD_W = RPM_W + RATE_W;
    localparam logic [RATE_W-1:0] OMEGA_CRANK_Q24 = 24'd9341469;
    localparam logic [RATE_W-1:0] OMEGA_FLY_Q24   = 24'd1756906;

    // flywheel angular speed, Q16.8
    localparam int OMEGA_W = 24;

    // k*omega + Tc rounded to Q.16
    localparam int S16_W = 33;

    // s16*omega in Q.24 and rounded to Q.16
    localparam int P_W   = S16_W + OMEGA_W;
    localparam int P16_W = P_W - 8;

    // 1/0.95 in Q1.24, product with the kept part of the power
    localparam int INV_W = 25;
    localparam logic [INV_W-1:0] INV_ETA_Q24 = 25'd17660227;
    localparam int Q_W      = S16_W + INV_W;
    localparam int Q_FRAC   = 40;
    localparam int W_RAW_W  = Q_W - Q_FRAC;

    // register stages from the accepted beat to the result strobe
    localparam int PIPE_STAGES = 8;

    // sensor mode register
    typedef enum logic {
        MODE_FLYWHEEL = 1'b0,
        MODE_CRANK    = 1'b1
    } t_sensor_mode;

    // eddy coefficient per level, units of 1e-10
    localparam int ROM_LEVELS = 22;
    localparam logic [31:0] K_ROM_E10 [ROM_LEVELS] = '{
        32'd308857954,  32'd308857954,  32'd308857954,  32'd308857954,
        32'd329923824,  32'd352426506,  32'd376463999,  32'd402140986,
        32'd429569289,  32'd458868358,  32'd507101318,  32'd560404182,
        32'd619309863,  32'd661181576,  32'd705884247,  32'd753609278,
        32'd920313744,  32'd1123894586, 32'd1123894586, 32'd1123894586,
        32'd1355586952, 32'd1635043007
    };

    // coulomb torque line, units of 1e-10
    localparam logic [63:0] TC_BASE_E10  = 64'd4338270944;
    localparam logic [63:0] TC_SLOPE_E10 = 64'd166779771;
    localparam logic [63:0] POW5_10      = 64'd9765625;

    // decimal value in 1e-10 units to unsigned fixed point, round to nearest
    function automatic logic [63:0] coef_q(input logic [63:0] units, input int frac);
        return ((units << (frac - 10)) + (POW5_10 - 64'd1) / 64'd2) / POW5_10;
    endfunction

endpackage

`default_nettype wire

/* hdl/ppe_coef_rom.sv */
// ppe_coef_rom: brake level clamp and lookup of the eddy coefficient k and
// the coulomb torque Tc, both built at elaboration; uses ppe_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppe_coef_rom
    import ppe_pkg::*;
#(
    parameter int LEVEL_COUNT    = 22,
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic [LEVEL_W-1:0]        i_level,
    output logic [COEF_FRAC_BITS-1:0] o_kq,
    output logic [COEF_FRAC_BITS:0]   o_tcq
);

    localparam int IDX_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

    logic [IDX_W-1:0]          w_idx;
    logic [COEF_FRAC_BITS-1:0] w_k_tab  [LEVEL_COUNT];
    logic [COEF_FRAC_BITS:0]   w_tc_tab [LEVEL_COUNT];

    // tables per clamped level; levels past the rom keep the last k
    for (genvar g = 0; g < LEVEL_COUNT; g++) begin : g_tab
        localparam int KI = (g < ROM_LEVELS) ? g : ROM_LEVELS - 1;
        localparam logic [63:0] KQ = coef_q({32'd0, K_ROM_E10[KI]}, COEF_FRAC_BITS);
        localparam logic [63:0] TQ =
            coef_q(TC_BASE_E10 + TC_SLOPE_E10 * 64'(g + 1), COEF_FRAC_BITS);
        assign w_k_tab[g]  = KQ[COEF_FRAC_BITS-1:0];
        assign w_tc_tab[g] = TQ[COEF_FRAC_BITS:0];
    end

    // clamp the level to 1..LEVEL_COUNT, as a table index
    always_comb begin
        priority if (i_level == '0) begin
            w_idx = '0;
        end else if (i_level > LEVEL_W'(LEVEL_COUNT)) begin
            w_idx = IDX_W'(LEVEL_COUNT - 1);
        end else begin
            w_idx = IDX_W'(i_level - LEVEL_W'(1));
        end
    end

    assign o_kq  = w_k_tab[w_idx];
    assign o_tcq = w_tc_tab[w_idx];

endmodule

`default_nettype wire

/* hdl/ppe_power_pipe.sv */
// ppe_power_pipe: eight-stage datapath from speed and level to watts, one
// multiply or one rounding add per stage; uses ppe_pkg and ppe_coef_rom
`timescale 1ns / 1ps
`default_nettype none

module ppe_power_pipe
    import ppe_pkg::*;
#(
    parameter int LEVEL_COUNT    = 22,
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_sensor_mode       i_mode,
    input  logic [RPM_W-1:0]   i_speed_rpm,
    input  logic [LEVEL_W-1:0] i_brake_level,
    output logic               o_valid,
    output logic [WATTS_W-1:0] o_watts
);

    localparam int KQ_W = COEF_FRAC_BITS;
    localparam int TC_W = COEF_FRAC_BITS + 1;
    localparam int KW_W = KQ_W + OMEGA_W;
    localparam int S_W  = KW_W + 1;

    // valid bits, one per stage
    logic [PIPE_STAGES-1:0] r_vld;

    // stage 1
    logic [RATE_W-1:0]      n_rate;
    logic [RATE_PROD_W-1:0] n_rate_prod;
    logic [KQ_W-1:0]        n_kq;
    logic [TC_W-1:0]        n_tc;
    logic [RATE_PROD_W-1:0] r1_prod;
    logic [KQ_W-1:0]        r1_kq;
    logic [TC_W-1:0]        r1_tc;
    logic                   r1_zero;
    // stage 2
    logic [RATE_PROD_W-1:0] n_prod_rnd;
    logic [OMEGA_W-1:0]     r2_omega;
    logic [KQ_W-1:0]        r2_kq;
    logic [TC_W-1:0]        r2_tc;
    logic                   r2_zero;
    // stage 3
    logic [KW_W-1:0]        r3_kw;
    logic [TC_W-1:0]        r3_tc;
    logic [OMEGA_W-1:0]     r3_omega;
    logic                   r3_zero;
    // stage 4
    logic [S_W-1:0]         n_s;
    logic [S16_W-1:0]       r4_s16;
    logic [OMEGA_W-1:0]     r4_omega;
    logic                   r4_zero;
    // stage 5
    logic [P_W-1:0]         r5_p;
    logic                   r5_zero;
    // stage 6
    logic [P_W-1:0]         n_p_rnd;
    logic [P16_W-1:0]       n_p16;
    logic [S16_W-1:0]       r6_p16;
    logic                   r6_big;
    logic                   r6_zero;
    // stage 7
    logic [Q_W-1:0]         r7_q;
    logic                   r7_big;
    logic                   r7_zero;
    // stage 8
    logic [Q_W-1:0]         n_q_rnd;
    logic [W_RAW_W-1:0]     n_w_raw;
    logic [WATTS_W-1:0]     n_watts;
    logic [WATTS_W-1:0]     r_watts;

    ppe_coef_rom #(
        .LEVEL_COUNT    (LEVEL_COUNT),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_coef_rom (
        .i_level (i_brake_level),
        .o_kq    (n_kq),
        .o_tcq   (n_tc)
    );

    // valid shift, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_STAGES-2:0], i_valid};
        end
    end

    // stage 1: rpm times the rad/s scale for the sensor mode
    assign n_rate      = (i_mode == MODE_CRANK) ? OMEGA_CRANK_Q24 : OMEGA_FLY_Q24;
    assign n_rate_prod = RATE_PROD_W'(i_speed_rpm) * RATE_PROD_W'(n_rate);

    // stage 2: round to omega in Q16.8
    assign n_prod_rnd = r1_prod + (RATE_PROD_W'(1) << 15);

    // stage 4: add torque term, round to Q.16
    assign n_s = S_W'(r3_kw) + S_W'({r3_tc, 8'd0}) + (S_W'(1) << (COEF_FRAC_BITS - 9));

    // stage 6: round power to Q.16
    assign n_p_rnd = r5_p + P_W'(128);
    assign n_p16   = n_p_rnd[P_W-1:8];

    // stage 8: round after the 1/0.95 scale and clamp
    assign n_q_rnd = r7_q + (Q_W'(1) << (Q_FRAC - 1));
    assign n_w_raw = n_q_rnd[Q_W-1:Q_FRAC];

    always_comb begin
        priority if (r7_zero) begin
            n_watts = '0;
        end else if (r7_big) begin
            n_watts = '1;
        end else if (n_w_raw == '0) begin
            n_watts = WATTS_W'(1);
        end else if (|n_w_raw[W_RAW_W-1:WATTS_W]) begin
            n_watts = '1;
        end else begin
            n_watts = n_w_raw[WATTS_W-1:0];
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r1_prod  <= n_rate_prod;
        r1_kq    <= n_kq;
        r1_tc    <= n_tc;
        r1_zero  <= (i_speed_rpm == '0);

        r2_omega <= n_prod_rnd[RATE_PROD_W-1:16];
        r2_kq    <= r1_kq;
        r2_tc    <= r1_tc;
        r2_zero  <= r1_zero;

        r3_kw    <= KW_W'(r2_kq) * KW_W'(r2_omega);
        r3_tc    <= r2_tc;
        r3_omega <= r2_omega;
        r3_zero  <= r2_zero;

        r4_s16   <= n_s[S_W-1:COEF_FRAC_BITS-8];
        r4_omega <= r3_omega;
        r4_zero  <= r3_zero;

        r5_p     <= P_W'(r4_s16) * P_W'(r4_omega);
        r5_zero  <= r4_zero;

        // power of 2^17 W or more ends at full scale
        r6_big   <= |n_p16[P16_W-1:S16_W];
        r6_p16   <= n_p16[S16_W-1:0];
        r6_zero  <= r5_zero;

        r7_q     <= Q_W'(r6_p16) * Q_W'(INV_ETA_Q24);
        r7_big   <= r6_big;
        r7_zero  <= r6_zero;

        r_watts  <= n_watts;
    end

    assign o_valid = r_vld[PIPE_STAGES-1];
    assign o_watts = r_watts;

endmodule

`default_nettype wire

/* hdl/pedal_power_estimator_unit.sv */
// pedal_power_estimator_unit: top level with the sensor mode register and
// the power pipeline; uses ppe_pkg and ppe_power_pipe
//
//  channel   signals                               direction  beat taken when
//  -------   -----------------------------------   ---------  ------------------------
//  config    i_cfg_we, i_cfg_wdata                 in         i_cfg_we high
//  request   start, busy, i_speed_rpm,             in         start high and busy low
//            i_brake_level
//  result    o_watts_valid, o_watts                out        o_watts_valid high
//
// one beat per clock cycle outside reset; each result passes through the pipeline
// registers: the four multiplies and their rounding stages, one per register
// busy is high only while reset is held; the result side cannot stall, so a
// strobe lasts one cycle and every request beat yields exactly one result
// reset clears the pipeline valid bits and sets crank sensor mode
`timescale 1ns / 1ps
`default_nettype none

module pedal_power_estimator_unit
    import ppe_pkg::*;
#(
    parameter int LEVEL_COUNT    = 22,
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic [RPM_W-1:0]   i_speed_rpm,
    input  logic [LEVEL_W-1:0] i_brake_level,
    output logic               o_watts_valid,
    output logic [WATTS_W-1:0] o_watts
);

    t_sensor_mode r_mode;
    t_sensor_mode n_mode;
    logic         w_accept;

    // sensor mode register
    assign n_mode = i_cfg_we ? t_sensor_mode'(i_cfg_wdata) : r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CRANK;
        end else begin
            r_mode <= n_mode;
        end
    end

    // request beat taken in every cycle with start high outside reset
    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    ppe_power_pipe #(
        .LEVEL_COUNT    (LEVEL_COUNT),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_power_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_accept),
        .i_mode        (r_mode),
        .i_speed_rpm   (i_speed_rpm),
        .i_brake_level (i_brake_level),
        .o_valid       (o_watts_valid),
        .o_watts       (o_watts)
    );

    // every result strobe comes from a matching request beat
    a_result_has_request : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_watts_valid |-> $past(w_accept, PIPE_STAGES))
        else $error("result strobe without a matching request beat");

    // zero watts exactly for a standstill request
    a_zero_is_standstill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_watts_valid |-> ((o_watts == '0) == $past(i_speed_rpm == '0, PIPE_STAGES)))
        else $error("zero watts does not match a standstill request");

    // a taken request always produces its result strobe
    a_request_has_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_accept, PIPE_STAGES) && $past(i_rst_n, PIPE_STAGES - 1) |-> o_watts_valid)
        else $error("request beat lost in the pipeline");

endmodule

`default_nettype wire

/* dv/tb_pedal_power_estimator_unit.sv */
// tb_pedal_power_estimator_unit: self-checking bench for the pedal power estimator,
// a directed table followed by random beats in both sensor modes, scored by a predictor
// depends on ppe_pkg and pedal_power_estimator_unit
`timescale 1ns / 1ps

module tb_pedal_power_estimator_unit;
    import ppe_pkg::*;

    localparam int LEVEL_MAX   = 22;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS    = 25;

    // rpm to rad/s factors, Q0.24, and 1/0.95 in Q1.24
    localparam logic [63:0] CRANK_RATE_Q24 = 64'd9341469;
    localparam logic [63:0] FLY_RATE_Q24   = 64'd1756906;
    localparam logic [63:0] INV_EFF_Q24    = 64'd17660227;
    localparam logic [63:0] TORQUE_BASE    = 64'd4338270944;
    localparam logic [63:0] TORQUE_SLOPE   = 64'd166779771;
    localparam logic [63:0] DEC_SCALE      = 64'd9765625;
    localparam logic [63:0] P16_CEIL       = (64'd1 << 48) - 64'd1;
    localparam logic [63:0] P16_SAT        = 64'd1 << 33;

    // eddy coefficient per brake level 1..22, units of 1e-10
    localparam logic [31:0] EDDY_K_E10 [LEVEL_MAX] = '{
        32'd308857954,  32'd308857954,  32'd308857954,  32'd308857954,
        32'd329923824,  32'd352426506,  32'd376463999,  32'd402140986,
        32'd429569289,  32'd458868358,  32'd507101318,  32'd560404182,
        32'd619309863,  32'd661181576,  32'd705884247,  32'd753609278,
        32'd920313744,  32'd1123894586, 32'd1123894586, 32'd1123894586,
        32'd1355586952, 32'd1635043007
    };

    typedef struct packed {
        logic [RPM_W-1:0]   rpm;
        logic [LEVEL_W-1:0] level;
        t_sensor_mode       mode;
        logic               typed;
        logic [WATTS_W-1:0] watts;
    } t_dir_row;

    typedef struct {
        logic [RPM_W-1:0]   rpm;
        logic [LEVEL_W-1:0] level;
        logic [WATTS_W-1:0] watts;
    } t_watts_due;

    // directed rows: typed watts only for standstill, saturation and the tiny-power floor
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{16'd0,     8'd1,   MODE_CRANK,    1'b1, 16'd0},
        '{16'd0,     8'd255, MODE_CRANK,    1'b1, 16'd0},
        '{16'd65535, 8'd22,  MODE_CRANK,    1'b1, 16'd65535},
        '{16'd65535, 8'd255, MODE_CRANK,    1'b1, 16'd65535},
        '{16'd60,    8'd0,   MODE_CRANK,    1'b0, 16'd0},
        '{16'd60,    8'd1,   MODE_CRANK,    1'b0, 16'd0},
        '{16'd60,    8'd4,   MODE_CRANK,    1'b0, 16'd0},
        '{16'd60,    8'd10,  MODE_CRANK,    1'b0, 16'd0},
        '{16'd60,    8'd13,  MODE_CRANK,    1'b0, 16'd0},
        '{16'd60,    8'd16,  MODE_CRANK,    1'b0, 16'd0},
        '{16'd60,    8'd18,  MODE_CRANK,    1'b0, 16'd0},
        '{16'd60,    8'd20,  MODE_CRANK,    1'b0, 16'd0},
        '{16'd60,    8'd22,  MODE_CRANK,    1'b0, 16'd0},
        '{16'd60,    8'd23,  MODE_CRANK,    1'b0, 16'd0},
        '{16'd90,    8'd128, MODE_CRANK,    1'b0, 16'd0},
        '{16'd1,     8'd1,   MODE_CRANK,    1'b0, 16'd0},
        '{16'd200,   8'd22,  MODE_CRANK,    1'b0, 16'd0},
        '{16'd0,     8'd10,  MODE_FLYWHEEL, 1'b1, 16'd0},
        '{16'd1,     8'd1,   MODE_FLYWHEEL, 1'b1, 16'd1},
        '{16'd1,     8'd0,   MODE_FLYWHEEL, 1'b1, 16'd1},
        '{16'd65535, 8'd1,   MODE_FLYWHEEL, 1'b1, 16'd65535},
        '{16'd500,   8'd22,  MODE_FLYWHEEL, 1'b0, 16'd0},
        '{16'd1000,  8'd13,  MODE_FLYWHEEL, 1'b0, 16'd0},
        '{16'd32768, 8'd8,   MODE_FLYWHEEL, 1'b0, 16'd0},
        '{16'd300,   8'd255, MODE_FLYWHEEL, 1'b0, 16'd0}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_wdata;
    logic               start;
    logic               busy;
    logic [RPM_W-1:0]   i_speed_rpm;
    logic [LEVEL_W-1:0] i_brake_level;
    logic               o_watts_valid;
    logic [WATTS_W-1:0] o_watts;

    // typed expectation that travels with the current beat
    logic               beat_typed;
    logic [WATTS_W-1:0] beat_watts;

    t_sensor_mode mode_model;
    t_sensor_mode drive_mode;
    t_watts_due   watts_due [$];
    int           err_cnt = 0;
    int           cycles = 0;

    pedal_power_estimator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .start         (start),
        .busy          (busy),
        .i_speed_rpm   (i_speed_rpm),
        .i_brake_level (i_brake_level),
        .o_watts_valid (o_watts_valid),
        .o_watts       (o_watts)
    );

    // clock, 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // decimal value in 1e-10 units to Q.24, round to nearest
    function automatic logic [63:0] e10_to_q24(input logic [63:0] units);
        return ((units << 14) + (DEC_SCALE - 64'd1) / 64'd2) / DEC_SCALE;
    endfunction

    // estimated pedal watts for one beat
    function automatic logic [WATTS_W-1:0] power_watts(input logic [RPM_W-1:0] rpm,
                                                       input logic [LEVEL_W-1:0] level,
                                                       input t_sensor_mode mode);
        logic [63:0] lvl, k_q, tc_q, rate, omega, s_q, s16, p_q, p16, w;
        if (rpm == '0) begin
            return '0;
        end
        lvl = 64'(level);
        if (lvl < 64'd1) lvl = 64'd1;
        if (lvl > 64'(LEVEL_MAX)) lvl = 64'(LEVEL_MAX);
        k_q  = e10_to_q24(64'(EDDY_K_E10[(lvl > 64'(LEVEL_MAX)) ? LEVEL_MAX - 1
                                                              : int'(lvl) - 1]));
        tc_q = e10_to_q24(TORQUE_BASE + TORQUE_SLOPE * lvl);
        rate = (mode == MODE_CRANK) ? CRANK_RATE_Q24 : FLY_RATE_Q24;
        // omega in Q16.8
        omega = (64'(rpm) * rate + (64'd1 << 15)) >> 16;
        // k*omega + Tc in Q.32, then Q.16
        s_q = k_q * omega + (tc_q << 8);
        s16 = (s_q + (64'd1 << 15)) >> 16;
        // power in Q.24, then a saturating Q.16 register
        p_q = s16 * omega;
        p16 = (p_q + 64'd128) >> 8;
        if (p16 > P16_CEIL) p16 = P16_CEIL;
        if (p16 >= P16_SAT) begin
            return '1;
        end
        w = (p16 * INV_EFF_Q24 + (64'd1 << 39)) >> 40;
        if (w < 64'd1) w = 64'd1;
        if (w > 64'd65535) w = 64'd65535;
        return w[WATTS_W-1:0];
    endfunction

    task automatic log_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%s", msg);
    endtask

    // request capture, mode shadow and result scoring
    always @(posedge i_clk) begin
        t_watts_due due;
        t_watts_due head;
        if (!i_rst_n) begin
            mode_model = MODE_CRANK;
        end else begin
            if (start && !busy) begin
                due.rpm   = i_speed_rpm;
                due.level = i_brake_level;
                due.watts = beat_typed ? beat_watts
                                       : power_watts(i_speed_rpm, i_brake_level, mode_model);
                watts_due.push_back(due);
            end
            if (i_cfg_we) mode_model = t_sensor_mode'(i_cfg_wdata);
        end
        if (o_watts_valid) begin
            if (watts_due.size() == 0) begin
                log_error($sformatf("unexpected result watts=%0d", o_watts));
            end else begin
                head = watts_due.pop_front();
                if (o_watts !== head.watts)
                    log_error($sformatf("watts mismatch rpm=%0d level=%0d exp=%0d got=%0d",
                                        head.rpm, head.level, head.watts, o_watts));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_pedal_power_estimator_unit: done, errors");
            $finish;
        end
    end

    // one request beat, held until taken
    task automatic drive_beat(input logic [RPM_W-1:0] rpm, input logic [LEVEL_W-1:0] level,
                              input logic typed, input logic [WATTS_W-1:0] watts);
        @(negedge i_clk);
        start         <= 1'b1;
        i_speed_rpm   <= rpm;
        i_brake_level <= level;
        beat_typed    <= typed;
        beat_watts    <= watts;
        do @(posedge i_clk); while (busy);
    endtask

    // idle burst with junk on the payload
    task automatic hold_off(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start         <= 1'b0;
            i_speed_rpm   <= RPM_W'($urandom);
            i_brake_level <= LEVEL_W'($urandom);
        end
    endtask

    // stop requests, drain, then write the mode register
    task automatic write_mode(input t_sensor_mode mode);
        @(negedge i_clk);
        start <= 1'b0;
        while (watts_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        drive_mode = mode;
    endtask

    // random beats, mostly riding speeds and valid levels, some full range
    task automatic random_beats(input int count, input int idle_pct);
        logic [RPM_W-1:0]   rpm;
        logic [LEVEL_W-1:0] level;
        int                 pick;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < idle_pct) hold_off($urandom_range(1, 17));
            pick = $urandom_range(99);
            if (pick < 8)
                rpm = '0;
            else if (pick < 60)
                rpm = (drive_mode == MODE_CRANK) ? RPM_W'($urandom_range(1, 180))
                                                 : RPM_W'($urandom_range(1, 1200));
            else if (pick < 85)
                rpm = RPM_W'($urandom_range(1, 4000));
            else
                rpm = RPM_W'($urandom);
            if ($urandom_range(99) < 80)
                level = LEVEL_W'($urandom_range(0, 24));
            else
                level = LEVEL_W'($urandom);
            drive_beat(rpm, level, 1'b0, '0);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        start         = 1'b0;
        i_speed_rpm   = '0;
        i_brake_level = '0;
        beat_typed    = 1'b0;
        beat_watts    = '0;
        drive_mode    = MODE_CRANK;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, mode switched between rows when it changes
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TABLE[r].mode != drive_mode) write_mode(DIR_TABLE[r].mode);
            if ($urandom_range(3) == 0) hold_off($urandom_range(1, 17));
            drive_beat(DIR_TABLE[r].rpm, DIR_TABLE[r].level,
                       DIR_TABLE[r].typed, DIR_TABLE[r].watts);
        end

        // random phases across both modes, last one back to back
        write_mode(MODE_CRANK);
        random_beats(120, 25);
        write_mode(MODE_FLYWHEEL);
        random_beats(120, 10);
        write_mode(MODE_CRANK);
        random_beats(100, 20);
        write_mode(MODE_FLYWHEEL);
        random_beats(110, 0);

        // drain and let the pipeline settle
        @(negedge i_clk);
        start <= 1'b0;
        while (watts_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_STAGES + 8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb_pedal_power_estimator_unit: done, clean");
        else
            $display("tb_pedal_power_estimator_unit: done, errors");
        $finish;
    end

endmodule
